// ===== rtl/ist_pkg.sv =====
// ---------------------------------------------------------------------------
// ist_pkg: shared types and constants of the interval set tracker
// Table size, coordinate width, action codes, cell commands and cell records.
// ---------------------------------------------------------------------------
package ist_pkg;

    localparam int MAX_INTERVALS = 16;
    localparam int COORD_BITS    = 32;
    localparam int CNT_W         = $clog2(MAX_INTERVALS + 1);

    // field widths of the stream payloads
    localparam int ACTION_W = 3;
    localparam int BOUND_W  = 32;
    localparam int COUNT_W  = 5;
    localparam int S_DATA_W = 72;
    localparam int M_DATA_W = 8;

    localparam logic [ACTION_W-1:0] ACT_FILL  = 3'd0;
    localparam logic [ACTION_W-1:0] ACT_CLEAR = 3'd1;
    localparam logic [ACTION_W-1:0] ACT_POINT = 3'd2;
    localparam logic [ACTION_W-1:0] ACT_ANY   = 3'd3;
    localparam logic [ACTION_W-1:0] ACT_ALL   = 3'd4;

    typedef logic [COORD_BITS-1:0] coord_t;

    typedef struct packed {
        logic   v;
        coord_t s;
        coord_t e;
    } cell_t;

    typedef struct packed {
        logic ov;        // shares a point with [l,h]
        logic below;     // lies wholly under l
        logic holds_cur; // contains the walk pointer
        logic s_lt_l;
        logic e_gt_h;
    } cell_flags_t;

    typedef enum logic [3:0] {
        CELL_HOLD       = 4'd0,
        CELL_FROM_LEFT  = 4'd1,
        CELL_FROM_RIGHT = 4'd2,
        CELL_INSERT     = 4'd3,
        CELL_WIDEN      = 4'd4,
        CELL_ABSORB     = 4'd5,
        CELL_TRIM_HI    = 4'd6,
        CELL_TRIM_LO    = 4'd7,
        CELL_SPLIT_HI   = 4'd8
    } cell_cmd_t;

    typedef enum logic [2:0] {
        ST_IDLE = 3'b001,
        ST_RUN  = 3'b010,
        ST_DONE = 3'b100
    } state_t;

endpackage

// ===== rtl/ist_cell.sv =====
// ---------------------------------------------------------------------------
// ist_cell: one table entry
// Holds one interval, compares it against the broadcast range and takes
// a new value from itself, a neighbour or the broadcast range as commanded.
// ---------------------------------------------------------------------------
module ist_cell (
    input  logic               aclk,
    input  logic               aresetn,
    input  ist_pkg::cell_cmd_t cmd,
    input  ist_pkg::cell_t     left_in,
    input  ist_pkg::cell_t     right_in,
    input  ist_pkg::coord_t    lo,
    input  ist_pkg::coord_t    hi,
    input  ist_pkg::coord_t    cur,
    output ist_pkg::cell_t     cell_out,
    output ist_pkg::cell_flags_t flags
);

    logic            v_reg, v_next;
    ist_pkg::coord_t s_reg, s_next;
    ist_pkg::coord_t e_reg, e_next;

    always_comb begin
        v_next = v_reg;
        s_next = s_reg;
        e_next = e_reg;
        case (cmd)
            ist_pkg::CELL_HOLD: ;
            ist_pkg::CELL_FROM_LEFT: begin
                v_next = left_in.v;
                s_next = left_in.s;
                e_next = left_in.e;
            end
            ist_pkg::CELL_FROM_RIGHT: begin
                v_next = right_in.v;
                s_next = right_in.s;
                e_next = right_in.e;
            end
            ist_pkg::CELL_INSERT: begin
                v_next = 1'b1;
                s_next = lo;
                e_next = hi;
            end
            ist_pkg::CELL_WIDEN: begin
                s_next = (lo < s_reg) ? lo : s_reg;
                e_next = (hi > e_reg) ? hi : e_reg;
            end
            ist_pkg::CELL_ABSORB:  e_next = right_in.e;
            ist_pkg::CELL_TRIM_HI: e_next = lo - ist_pkg::coord_t'(1);
            ist_pkg::CELL_TRIM_LO: s_next = hi + ist_pkg::coord_t'(1);
            ist_pkg::CELL_SPLIT_HI: begin
                v_next = 1'b1;
                s_next = hi + ist_pkg::coord_t'(1);
                e_next = left_in.e;
            end
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v_reg <= 1'b0;
        end else begin
            v_reg <= v_next;
        end
    end

    always_ff @(posedge aclk) begin
        s_reg <= s_next;
        e_reg <= e_next;
    end

    assign cell_out.v = v_reg;
    assign cell_out.s = s_reg;
    assign cell_out.e = e_reg;

    assign flags.ov        = v_reg && (s_reg <= hi) && (e_reg >= lo);
    assign flags.below     = v_reg && (e_reg < lo);
    assign flags.holds_cur = v_reg && (s_reg <= cur) && (e_reg >= cur);
    assign flags.s_lt_l    = s_reg < lo;
    assign flags.e_gt_h    = e_reg > hi;

endmodule

// ===== rtl/interval_set_tracker.sv =====
// ---------------------------------------------------------------------------
// interval_set_tracker: sorted table of disjoint closed intervals
// Fill, clear and coverage queries over a row of interval cells.
// ---------------------------------------------------------------------------
//  channel | dir | fields (tdata, lowest bit up)
//  s_      | in  | action[2:0], range_low[34:3], range_high[66:35], zero pad
//  m_      | out | hit[0], table_full_error[1], interval_count[6:2], zero pad
//
//  One transfer in, one out. An item passes ST_RUN, one step of the sequencer
//  at a time with at least one step, then ST_DONE: a fill merges one extra
//  overlapped entry per step, a clear trims or drops one entry per step, and an
//  all-covered query walks one abutting entry per step.
//  Reset clears every valid mark at once; no clearing pass.
//  A new item is taken while the previous result still waits on m_tready.
// ---------------------------------------------------------------------------
module interval_set_tracker (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         s_tvalid,
    output logic                         s_tready,
    // action, range_low, range_high, zero pad
    input  logic [ist_pkg::S_DATA_W-1:0] s_tdata,
    output logic                         m_tvalid,
    input  logic                         m_tready,
    // hit, table_full_error, interval_count, zero pad
    output logic [ist_pkg::M_DATA_W-1:0] m_tdata
);

    // ---- item register ----
    ist_pkg::state_t                 state_reg, state_next;
    logic [ist_pkg::ACTION_W-1:0]    action_reg;
    ist_pkg::coord_t                 lo_reg, hi_reg, cur_reg, cur_next;
    logic                            empty_reg;
    logic [ist_pkg::CNT_W-1:0]       count_reg, count_next;
    logic                            hit_reg, hit_next, err_reg, err_next;

    // ---- output register ----
    logic                            m_tvalid_reg;
    logic [ist_pkg::M_DATA_W-1:0]    m_tdata_reg;

    logic [ist_pkg::ACTION_W-1:0]    in_action;
    ist_pkg::coord_t                 in_lo, in_hi;
    logic                            in_xfer, out_free;

    assign in_action = s_tdata[2:0];
    assign in_lo     = s_tdata[3 +: ist_pkg::COORD_BITS];
    assign in_hi     = s_tdata[35 +: ist_pkg::COORD_BITS];
    assign s_tready  = (state_reg == ist_pkg::ST_IDLE);
    assign in_xfer   = s_tvalid && s_tready;
    assign out_free  = !m_tvalid_reg || m_tready;

    // ---- cell row ----
    ist_pkg::cell_t       cells [ist_pkg::MAX_INTERVALS];
    ist_pkg::cell_flags_t flags [ist_pkg::MAX_INTERVALS];
    ist_pkg::cell_cmd_t   cmd   [ist_pkg::MAX_INTERVALS];

    genvar g;
    generate
        for (g = 0; g < ist_pkg::MAX_INTERVALS; g++) begin : g_cell
            ist_pkg::cell_t left_c, right_c;
            if (g == 0) begin : g_first
                assign left_c = '0;
            end else begin : g_mid_l
                assign left_c = cells[g-1];
            end
            if (g == ist_pkg::MAX_INTERVALS - 1) begin : g_last
                assign right_c = '0;
            end else begin : g_mid_r
                assign right_c = cells[g+1];
            end
            ist_cell u_cell (
                .aclk     (aclk),
                .aresetn  (aresetn),
                .cmd      (cmd[g]),
                .left_in  (left_c),
                .right_in (right_c),
                .lo       (lo_reg),
                .hi       (hi_reg),
                .cur      (cur_reg),
                .cell_out (cells[g]),
                .flags    (flags[g])
            );
        end
    endgenerate

    // ---- row summary: first overlapped entry, insert slot, walk target ----
    logic [ist_pkg::MAX_INTERVALS-1:0] first_oh, after_f, ins_oh, after_ins;
    logic            any_ov, second_ov, f_slt, f_egt, any_cur;
    ist_pkg::coord_t e_sel;

    always_comb begin
        logic seen_ov, seen_f, seen_ins, prev_below;
        seen_ov    = 1'b0;
        seen_f     = 1'b0;
        seen_ins   = 1'b0;
        prev_below = 1'b1;
        second_ov  = 1'b0;
        f_slt      = 1'b0;
        f_egt      = 1'b0;
        any_cur    = 1'b0;
        e_sel      = '0;
        for (int i = 0; i < ist_pkg::MAX_INTERVALS; i++) begin
            first_oh[i]  = flags[i].ov && !seen_ov;
            after_f[i]   = seen_f;
            ins_oh[i]    = !flags[i].below && prev_below;
            after_ins[i] = seen_ins;
            if (i > 0 && first_oh[i-1] && flags[i].ov) begin
                second_ov = 1'b1;
            end
            if (first_oh[i]) begin
                f_slt = flags[i].s_lt_l;
                f_egt = flags[i].e_gt_h;
            end
            if (flags[i].holds_cur) begin
                any_cur = 1'b1;
                e_sel   = e_sel | cells[i].e;
            end
            seen_ov    = seen_ov | flags[i].ov;
            seen_f     = seen_f | first_oh[i];
            seen_ins   = seen_ins | ins_oh[i];
            prev_below = flags[i].below;
        end
        any_ov = seen_ov;
    end

    // ---- sequencer step ----
    logic full, step_done;
    assign full = (count_reg == ist_pkg::CNT_W'(ist_pkg::MAX_INTERVALS));

    always_comb begin
        step_done  = 1'b0;
        hit_next   = 1'b0;
        err_next   = 1'b0;
        count_next = count_reg;
        cur_next   = cur_reg;
        for (int i = 0; i < ist_pkg::MAX_INTERVALS; i++) begin
            cmd[i] = ist_pkg::CELL_HOLD;
        end
        if (state_reg == ist_pkg::ST_RUN) begin
            case (action_reg)
                ist_pkg::ACT_FILL: begin
                    if (empty_reg) begin
                        step_done = 1'b1;
                    end else if (!any_ov) begin
                        step_done = 1'b1;
                        if (full) begin
                            err_next = 1'b1;
                        end else begin
                            count_next = count_reg + ist_pkg::CNT_W'(1);
                            for (int i = 0; i < ist_pkg::MAX_INTERVALS; i++) begin
                                if (ins_oh[i]) cmd[i] = ist_pkg::CELL_INSERT;
                                else if (after_ins[i]) cmd[i] = ist_pkg::CELL_FROM_LEFT;
                            end
                        end
                    end else if (second_ov) begin
                        // fold the next overlapped entry into the first one
                        count_next = count_reg - ist_pkg::CNT_W'(1);
                        for (int i = 0; i < ist_pkg::MAX_INTERVALS; i++) begin
                            if (first_oh[i]) cmd[i] = ist_pkg::CELL_ABSORB;
                            else if (after_f[i]) cmd[i] = ist_pkg::CELL_FROM_RIGHT;
                        end
                    end else begin
                        step_done = 1'b1;
                        for (int i = 0; i < ist_pkg::MAX_INTERVALS; i++) begin
                            if (first_oh[i]) cmd[i] = ist_pkg::CELL_WIDEN;
                        end
                    end
                end
                ist_pkg::ACT_CLEAR: begin
                    if (empty_reg || !any_ov) begin
                        step_done = 1'b1;
                    end else if (f_slt && f_egt) begin
                        // range strictly inside one entry: split it
                        step_done = 1'b1;
                        if (full) begin
                            err_next = 1'b1;
                        end else begin
                            count_next = count_reg + ist_pkg::CNT_W'(1);
                            for (int i = 0; i < ist_pkg::MAX_INTERVALS; i++) begin
                                if (first_oh[i]) begin
                                    cmd[i] = ist_pkg::CELL_TRIM_HI;
                                end else if (i > 0 && first_oh[i-1]) begin
                                    cmd[i] = ist_pkg::CELL_SPLIT_HI;
                                end else if (after_f[i]) begin
                                    cmd[i] = ist_pkg::CELL_FROM_LEFT;
                                end
                            end
                        end
                    end else if (f_slt) begin
                        for (int i = 0; i < ist_pkg::MAX_INTERVALS; i++) begin
                            if (first_oh[i]) cmd[i] = ist_pkg::CELL_TRIM_HI;
                        end
                    end else if (f_egt) begin
                        for (int i = 0; i < ist_pkg::MAX_INTERVALS; i++) begin
                            if (first_oh[i]) cmd[i] = ist_pkg::CELL_TRIM_LO;
                        end
                    end else begin
                        count_next = count_reg - ist_pkg::CNT_W'(1);
                        for (int i = 0; i < ist_pkg::MAX_INTERVALS; i++) begin
                            if (first_oh[i] || after_f[i]) cmd[i] = ist_pkg::CELL_FROM_RIGHT;
                        end
                    end
                end
                ist_pkg::ACT_POINT, ist_pkg::ACT_ANY: begin
                    step_done = 1'b1;
                    hit_next  = !empty_reg && any_ov;
                end
                ist_pkg::ACT_ALL: begin
                    if (empty_reg || !any_cur) begin
                        step_done = 1'b1;
                    end else if (e_sel >= hi_reg) begin
                        step_done = 1'b1;
                        hit_next  = 1'b1;
                    end else begin
                        cur_next = e_sel + ist_pkg::coord_t'(1);
                    end
                end
                default: step_done = 1'b1;
            endcase
        end
    end

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ist_pkg::ST_IDLE: if (in_xfer) state_next = ist_pkg::ST_RUN;
            ist_pkg::ST_RUN:  if (step_done) state_next = ist_pkg::ST_DONE;
            ist_pkg::ST_DONE: if (out_free) state_next = ist_pkg::ST_IDLE;
            default:          state_next = ist_pkg::ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ist_pkg::ST_IDLE;
            count_reg    <= '0;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            count_reg <= count_next;
            if (state_reg == ist_pkg::ST_DONE && out_free) begin
                m_tvalid_reg <= 1'b1;
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (in_xfer) begin
            action_reg <= in_action;
            lo_reg     <= in_lo;
            cur_reg    <= in_lo;
            // a point query looks at [low,low]
            hi_reg     <= (in_action == ist_pkg::ACT_POINT) ? in_lo : in_hi;
            empty_reg  <= (in_action != ist_pkg::ACT_POINT) && (in_lo > in_hi);
        end else begin
            cur_reg <= cur_next;
        end
        if (state_reg == ist_pkg::ST_RUN && step_done) begin
            hit_reg <= hit_next;
            err_reg <= err_next;
        end
        if (state_reg == ist_pkg::ST_DONE && out_free) begin
            m_tdata_reg <= {1'b0, ist_pkg::COUNT_W'(count_reg), err_reg, hit_reg};
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

endmodule

// ===== rtl/ist_checker.sv =====
// ---------------------------------------------------------------------------
// ist_checker: port-level checks of the interval set tracker
// Watches the two stream channels and the reported count.
// ---------------------------------------------------------------------------
module ist_checker (
    input logic                         aclk,
    input logic                         aresetn,
    input logic                         s_tvalid,
    input logic                         s_tready,
    input logic                         m_tvalid,
    input logic                         m_tready,
    input logic [ist_pkg::M_DATA_W-1:0] m_tdata
);

    // a waiting result stays offered
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid)
        else $error("result dropped while stalled");

    // one item at a time: no transfer straight after a transfer
    a_one_item: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !s_tready)
        else $error("input taken while busy");

    a_count_max: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> m_tdata[6:2] <= ist_pkg::COUNT_W'(ist_pkg::MAX_INTERVALS))
        else $error("interval count out of range");

    // a dropped operation only happens on a full table
    a_err_full: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tdata[1] |->
            m_tdata[6:2] == ist_pkg::COUNT_W'(ist_pkg::MAX_INTERVALS))
        else $error("table_full_error with room left");

    a_hit_err: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> !(m_tdata[0] && m_tdata[1]))
        else $error("hit and error together");

endmodule

bind interval_set_tracker ist_checker u_ist_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);
